// File: design/rpfe_pkg.sv
// Shared types and codes for the PPM frame encoder.
package rpfe_pkg;

  // Request types on the input channel.
  localparam logic [1:0] REQ_CAL = 2'd0;
  localparam logic [1:0] REQ_RAW = 2'd1;
  localparam logic [1:0] REQ_COMMIT = 2'd2;
  localparam logic [1:0] REQ_CMP = 2'd3;

  // Calibration word fields.
  localparam logic [2:0] FLD_LOW = 3'd0;
  localparam logic [2:0] FLD_CEN = 3'd1;
  localparam logic [2:0] FLD_HIGH = 3'd2;
  localparam logic [2:0] FLD_DZ = 3'd3;
  localparam logic [2:0] FLD_TRIM = 3'd4;
  localparam logic [2:0] FLD_LAST = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CHMAP = 3'd0;
  localparam logic [2:0] CFG_MIN_PULSE = 3'd1;
  localparam logic [2:0] CFG_PAUSE = 3'd2;
  localparam logic [2:0] CFG_SYNC = 3'd3;
  localparam logic [2:0] CFG_SCALE = 3'd4;
  localparam logic [2:0] CFG_PERIOD = 3'd5;

  localparam int NUM_SRC = 8;
  localparam int CAL_DEPTH = 40;
  localparam int DIV_STEPS = 32;

  localparam logic [23:0] CHMAP_RST = 24'd16434824;
  localparam logic [15:0] MIN_PULSE_RST = 16'd1000;
  localparam logic [15:0] PAUSE_RST = 16'd300;
  localparam logic [15:0] SYNC_RST = 16'd20000;
  localparam logic [13:0] SCALE_RST = 14'd500;
  localparam logic [15:0] PERIOD_RST = 16'd22500;

  // Datapath step for one output slot of a commit.
  typedef enum logic [3:0] {
    ST_NONE,
    ST_RD_CEN,
    ST_SUM,
    ST_DZ,
    ST_TRIM,
    ST_HI,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_WRITE
  } dp_step_t;

  typedef struct packed {
    logic     acc_cal;
    logic     acc_raw;
    logic     acc_cmp;
    dp_step_t step;
    logic     last;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

// File: design/rpfe_ctrl.sv
// Sequencer for request acceptance and the per-slot commit steps.
module rpfe_ctrl #(
  parameter int NUM_CHANNELS = 8,
  parameter int SW = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_req_type,
  output logic                 in_stall,
  input  logic                 out_stall,
  input  rpfe_pkg::dp_status_t status,
  output rpfe_pkg::dp_cmd_t    cmd,
  output logic [SW-1:0]        slot
);
  import rpfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_CEN, S_SUM, S_DZ, S_TRIM, S_HI, S_SETUP, S_MUL, S_DIV, S_WRITE
  } state_t;

  localparam logic [SW-1:0] LAST_SLOT = SW'(NUM_CHANNELS - 1);

  state_t        state_r, state_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic          accept;

  assign in_stall = (state_r != S_IDLE) ||
                    ((in_req_type == REQ_CMP) && status.out_full && out_stall);
  assign accept = in_valid && !in_stall;
  assign slot = slot_r;

  always_comb begin
    cmd.acc_cal = accept && (in_req_type == REQ_CAL);
    cmd.acc_raw = accept && (in_req_type == REQ_RAW);
    cmd.acc_cmp = accept && (in_req_type == REQ_CMP);
    cmd.last = (slot_r == LAST_SLOT);
    case (state_r)
      S_RD_CEN: cmd.step = ST_RD_CEN;
      S_SUM:    cmd.step = ST_SUM;
      S_DZ:     cmd.step = ST_DZ;
      S_TRIM:   cmd.step = ST_TRIM;
      S_HI:     cmd.step = ST_HI;
      S_SETUP:  cmd.step = ST_SETUP;
      S_MUL:    cmd.step = ST_MUL;
      S_DIV:    cmd.step = ST_DIV;
      S_WRITE:  cmd.step = ST_WRITE;
      default:  cmd.step = ST_NONE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    slot_nxt = slot_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_req_type == REQ_COMMIT)) begin
          state_nxt = S_RD_CEN;
          slot_nxt = '0;
        end
      end
      S_RD_CEN: state_nxt = S_SUM;
      S_SUM:    state_nxt = S_DZ;
      S_DZ:     state_nxt = S_TRIM;
      S_TRIM:   state_nxt = S_HI;
      S_HI:     state_nxt = S_SETUP;
      S_SETUP:  state_nxt = S_MUL;
      S_MUL:    state_nxt = S_DIV;
      S_DIV: begin
        if (status.div_done) state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (slot_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RD_CEN;
          slot_nxt = slot_r + SW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_r <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

// File: design/rpfe_dp.sv
// Storage, calibration arithmetic, serial divider and compare generation.
module rpfe_dp #(
  parameter int NUM_CHANNELS = 8,
  parameter int SW = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rpfe_pkg::dp_cmd_t    cmd,
  input  logic [SW-1:0]        slot,
  output rpfe_pkg::dp_status_t status,
  input  logic [2:0]           in_channel,
  input  logic [2:0]           in_cal_field,
  input  logic signed [15:0]   in_value,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [23:0]          cfg_wdata,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [15:0]          out_compare_value,
  output logic [4:0]           out_frame_slot
);
  import rpfe_pkg::*;

  localparam logic [4:0] N2 = 5'(2 * NUM_CHANNELS);

  // Configuration
  logic [23:0] chmap_r;
  logic [15:0] min_pulse_r, pause_r, sync_r, period_r;
  logic [13:0] scale_r;

  // Stores
  logic signed [15:0] cal_mem [CAL_DEPTH];
  logic signed [15:0] cal_rd_r;
  logic [5:0]         rd_addr;
  logic signed [15:0] raw_r [NUM_SRC];
  logic [15:0]        width_r [2][NUM_CHANNELS];
  logic               active_r;
  logic [4:0]         pos_r;
  logic [15:0]        acc_r;

  // Per-slot arithmetic
  logic [2:0]         src;
  logic signed [17:0] s_r, dz;
  logic signed [15:0] hi_r;
  logic               pos_br_r, neg_r, zero_r;
  logic [17:0]        amag_r;
  logic [16:0]        dmag_r;
  logic signed [18:0] lo_x, a_x, d_x;
  logic [31:0]        quo_r;
  logic [16:0]        rem_r;
  logic [17:0]        rem_sh;
  logic [4:0]         cnt_r;
  logic signed [33:0] q_s, f_s, rq, r_pre, r_clamp;
  logic [15:0]        w_new;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_cv_r;
  logic [4:0]  out_fs_r;
  logic [15:0] add_val;

  assign src = chmap_r[3*slot +: 3];

  always_comb begin
    case (cmd.step)
      ST_RD_CEN: rd_addr = {FLD_CEN, src};
      ST_SUM:    rd_addr = {FLD_DZ, src};
      ST_DZ:     rd_addr = {FLD_TRIM, src};
      ST_TRIM:   rd_addr = {FLD_HIGH, src};
      ST_HI:     rd_addr = {FLD_LOW, src};
      default:   rd_addr = {FLD_CEN, src};
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_cal && (in_cal_field <= FLD_LAST)) begin
      cal_mem[{in_cal_field, in_channel}] <= in_value;
    end
    cal_rd_r <= cal_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chmap_r <= CHMAP_RST;
      min_pulse_r <= MIN_PULSE_RST;
      pause_r <= PAUSE_RST;
      sync_r <= SYNC_RST;
      scale_r <= SCALE_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CHMAP:     chmap_r <= cfg_wdata;
        CFG_MIN_PULSE: min_pulse_r <= cfg_wdata[15:0];
        CFG_PAUSE:     pause_r <= cfg_wdata[15:0];
        CFG_SYNC:      sync_r <= cfg_wdata[15:0];
        CFG_SCALE:     scale_r <= cfg_wdata[13:0];
        CFG_PERIOD:    period_r <= cfg_wdata[15:0];
        default:       ;
      endcase
    end
  end

  // Step arithmetic
  assign dz = 18'(cal_rd_r);
  assign lo_x = 19'(cal_rd_r);
  assign a_x = pos_br_r ? 19'(s_r) : 19'(s_r) - lo_x;
  assign d_x = pos_br_r ? 19'(hi_r) : -lo_x;
  assign rem_sh = {rem_r, quo_r[31]};

  assign q_s = 34'(quo_r);
  assign f_s = 34'(scale_r);
  assign rq = neg_r ? -q_s : q_s;
  always_comb begin
    if (zero_r) r_pre = pos_br_r ? f_s : -f_s;
    else        r_pre = pos_br_r ? rq : rq - f_s;
    if (r_pre > f_s)       r_clamp = f_s;
    else if (r_pre < -f_s) r_clamp = -f_s;
    else                   r_clamp = r_pre;
  end
  assign w_new = 16'(r_clamp) + min_pulse_r + 16'(scale_r) - pause_r;

  always_ff @(posedge clk) begin
    case (cmd.step)
      ST_SUM:  s_r <= 18'(raw_r[src]) + 18'(cal_rd_r);
      ST_DZ: begin
        if ((s_r < dz) && (s_r > -dz)) s_r <= '0;
        pos_br_r <= 1'b0;
      end
      ST_TRIM: begin
        s_r <= s_r + 18'(cal_rd_r);
        pos_br_r <= (s_r + 18'(cal_rd_r)) > 18'sd0;
      end
      ST_HI:   hi_r <= cal_rd_r;
      ST_SETUP: begin
        amag_r <= a_x[18] ? 18'(-a_x) : 18'(a_x);
        dmag_r <= d_x[18] ? 17'(-d_x) : 17'(d_x);
        neg_r <= a_x[18] ^ d_x[18];
        zero_r <= (d_x == 19'sd0);
      end
      ST_MUL: begin
        quo_r <= 32'(amag_r) * 32'(scale_r);
        rem_r <= '0;
        cnt_r <= '0;
      end
      ST_DIV: begin
        if (rem_sh >= 18'(dmag_r)) begin
          rem_r <= 17'(rem_sh - 18'(dmag_r));
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rem_sh[16:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
      end
      default: ;
    endcase
  end

  assign status.div_done = (cnt_r == 5'(DIV_STEPS - 1));
  assign status.out_full = out_valid_r;

  // Frame state, sample registers and slot buffers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SRC; i++) raw_r[i] <= '0;
      for (int b = 0; b < 2; b++)
        for (int i = 0; i < NUM_CHANNELS; i++) width_r[b][i] <= MIN_PULSE_RST;
      active_r <= 1'b0;
    end else begin
      if (cmd.acc_raw) raw_r[in_channel] <= in_value;
      if (cmd.step == ST_WRITE) begin
        width_r[~active_r][slot] <= w_new;
        if (cmd.last) active_r <= ~active_r;
      end
    end
  end

  assign add_val = pos_r[0] ? pause_r : width_r[active_r][pos_r[SW:1]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (cmd.acc_cmp) begin
        out_valid_r <= 1'b1;
        if (pos_r < N2) begin
          acc_r <= acc_r + add_val;
          out_cv_r <= acc_r + add_val;
          out_fs_r <= pos_r;
          pos_r <= pos_r + 5'd1;
        end else if (pos_r == N2) begin
          acc_r <= sync_r;
          out_cv_r <= sync_r;
          out_fs_r <= N2;
          pos_r <= N2 + 5'd1;
        end else begin
          acc_r <= '0;
          out_cv_r <= period_r;
          out_fs_r <= N2 + 5'd1;
          pos_r <= '0;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_compare_value = out_cv_r;
  assign out_frame_slot = out_fs_r;

endmodule

// File: design/rc_ppm_frame_encoder_core.sv
// Top level of the calibrated PPM frame encoder.
//
// Input channel (in_valid/in_stall) carries one request per handshake:
// a calibration word, a raw sample, a frame commit or a timer compare match.
// Only a compare match produces a result on the output channel
// (out_valid/out_stall): the next compare value and the frame slot issued,
// loaded into the output register in the cycle after the request is taken.
// A commit walks the output slots one at a time: per slot, seven steps read
// the calibration store and form the scaled operands, then a restoring divider
// retires one quotient bit per cycle until all 32 bits are formed, then the
// slot width is written into the inactive buffer. in_stall stays high for
// the whole commit.
// The divider sets the commit rate.
// When the receiver stalls, the result holds in the output register; further
// non-compare requests are still taken, a compare request waits.
// Reset (rst_n low, synchronous) restores the configuration defaults, clears
// samples, frame position and compare accumulator, and fills both slot
// buffers with the default minimum pulse. Calibration words hold no value
// until written.
module rc_ppm_frame_encoder_core #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [2:0]         in_channel,
  input  logic [2:0]         in_cal_field,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_compare_value,
  output logic [4:0]         out_frame_slot,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);
  import rpfe_pkg::*;

  // Slot index width, at least one bit.
  localparam int SW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [SW-1:0] slot;

  // Sequencer: accepts requests and steps the commit.
  rpfe_ctrl #(.NUM_CHANNELS(NUM_CHANNELS), .SW(SW)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .out_stall   (out_stall),
    .status      (status),
    .cmd         (cmd),
    .slot        (slot)
  );

  // Datapath: stores, calibration math, divider, compare output.
  rpfe_dp #(.NUM_CHANNELS(NUM_CHANNELS), .SW(SW)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .slot              (slot),
    .status            (status),
    .in_channel        (in_channel),
    .in_cal_field      (in_cal_field),
    .in_value          (in_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_compare_value (out_compare_value),
    .out_frame_slot    (out_frame_slot)
  );

endmodule

// File: design/rpfe_checker.sv
// Port-level checks for the PPM frame encoder, bound to the top level.
module rpfe_checker #(
  parameter int NUM_CHANNELS = 8
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_compare_value,
  input logic [4:0]  out_frame_slot
);
  import rpfe_pkg::*;

  localparam logic [4:0] LAST_POS = 5'(2 * NUM_CHANNELS + 1);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_slot <= LAST_POS)
    else $error("frame slot out of range");

  a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_req_type == REQ_COMMIT) |=> in_stall)
    else $error("request taken during commit");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_compare_value)
      && $stable(out_frame_slot))
    else $error("stalled result changed");

endmodule

bind rc_ppm_frame_encoder_core rpfe_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_rpfe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_req_type       (in_req_type),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_compare_value (out_compare_value),
  .out_frame_slot    (out_frame_slot)
);

// File: tb/sv/rc_ppm_frame_encoder_core_test.sv
// Self-checking testbench for the calibrated PPM frame encoder core.
module rc_ppm_frame_encoder_core_test;
  import rpfe_pkg::*;

  typedef struct {
    logic [1:0]  req;
    logic [2:0]  ch;
    logic [2:0]  fld;
    logic [15:0] val;
  } ppm_req_t;

  typedef struct {
    logic [15:0] cmp;
    logic [4:0]  slot;
  } ppm_cmp_t;

  localparam int FRAME_POS = 2 * 8;
  localparam int DRAIN_CYCLES = 400;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_req_type;
  logic [2:0] in_channel;
  logic [2:0] in_cal_field;
  logic signed [15:0] in_value;
  logic out_valid;
  logic out_stall;
  logic [15:0] out_compare_value;
  logic [4:0] out_frame_slot;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [23:0] cfg_wdata;

  rc_ppm_frame_encoder_core DUT (.*);

  // Requests waiting to be offered, and compare results still owed.
  ppm_req_t req_queue[$];
  ppm_cmp_t cmp_queue[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic long_hold_req = 1'b0;

  // Shadow configuration and state of the encoder.
  logic [23:0] m_chmap;
  logic [15:0] m_min_pulse, m_pause, m_sync, m_period;
  logic [13:0] m_scale;
  logic [15:0] m_cal[CAL_DEPTH];
  logic [15:0] m_raw[8];
  logic [15:0] m_slot[2][8];
  logic m_act;
  logic [4:0] m_pos;
  logic [15:0] m_acc;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint sx(logic [15:0] x);
    return longint'($signed(x));
  endfunction

  // Calibrate and scale one source channel to +/- full scale.
  function automatic longint deflection(int src);
    longint f, s, dz, hi, lo, r;
    f = m_scale;
    s = sx(m_raw[src]) + sx(m_cal[8 + src]);
    dz = sx(m_cal[24 + src]);
    if (s < dz && s > -dz) s = 0;
    s += sx(m_cal[32 + src]);
    if (s > 0) begin
      hi = sx(m_cal[16 + src]);
      r = (hi == 0) ? f : (s * f) / hi;
    end else begin
      lo = sx(m_cal[src]);
      r = (lo == 0) ? -f : ((s - lo) * f) / (-lo) - f;
    end
    if (r > f) r = f;
    if (r < -f) r = -f;
    return r;
  endfunction

  // Advance the shadow state by one accepted request.
  task automatic encode_request(ppm_req_t r);
    ppm_cmp_t e;
    longint w;
    logic nb;
    case (r.req)
      REQ_CAL: if (r.fld <= FLD_LAST) m_cal[r.fld * 8 + r.ch] = r.val;
      REQ_RAW: m_raw[r.ch] = r.val;
      REQ_COMMIT: begin
        nb = ~m_act;
        for (int i = 0; i < 8; i++) begin
          w = deflection(int'(m_chmap[3 * i +: 3])) + m_min_pulse + m_scale - m_pause;
          m_slot[nb][i] = w[15:0];
        end
        m_act = nb;
      end
      default: begin
        if (m_pos < FRAME_POS) begin
          m_acc = m_acc + (m_pos[0] ? m_pause : m_slot[m_act][m_pos[3:1]]);
          e.cmp = m_acc;
          e.slot = m_pos;
          m_pos = m_pos + 5'd1;
        end else if (m_pos == FRAME_POS) begin
          m_acc = m_sync;
          e.cmp = m_acc;
          e.slot = m_pos;
          m_pos = m_pos + 5'd1;
        end else begin
          m_pos = '0;
          m_acc = '0;
          e.cmp = m_period;
          e.slot = 5'(FRAME_POS + 1);
        end
        cmp_queue.push_back(e);
      end
    endcase
  endtask

  task automatic report_mismatch(string what);
    errors++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  // Driver: hold a stalled request, otherwise offer the next or idle.
  always @(posedge clk) begin
    ppm_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      // hold the payload until accepted
    end else begin
      if (in_valid) encode_request('{in_req_type, in_channel, in_cal_field, in_value});
      if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_queue.pop_front();
        in_valid <= 1'b1;
        in_req_type <= nxt.req;
        in_channel <= nxt.ch;
        in_cal_field <= nxt.fld;
        in_value <= nxt.val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted in cycles.
  int hold_cnt = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin
    if (long_hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 1500;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // Monitor: check accepted results and drive the receiver stall.
  always @(posedge clk) begin
    ppm_cmp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (cmp_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result cmp=%0d slot=%0d",
                                  out_compare_value, out_frame_slot));
      end else begin
        e = cmp_queue.pop_front();
        if (out_compare_value !== e.cmp)
          report_mismatch($sformatf("compare value %0d, want %0d", out_compare_value, e.cmp));
        if (out_frame_slot !== e.slot)
          report_mismatch($sformatf("frame slot %0d, want %0d", out_frame_slot, e.slot));
      end
    end
    if ((long_hold_req && !hold_done) || hold_cnt > 0) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog.
  longint cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rc_ppm_frame_encoder_core_test failed");
      $finish;
    end
  end

  function automatic logic [15:0] pick_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      4, 5: return 16'($signed($urandom_range(1200)) - 600);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_req(logic [1:0] rq, logic [2:0] ch, logic [2:0] fld, logic [15:0] v);
    req_queue.push_back('{rq, ch, fld, v});
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CHMAP: m_chmap = v;
      CFG_MIN_PULSE: m_min_pulse = v[15:0];
      CFG_PAUSE: m_pause = v[15:0];
      CFG_SYNC: m_sync = v[15:0];
      CFG_SCALE: m_scale = v[13:0];
      default: m_period = v[15:0];
    endcase
  endtask

  // Wait until every request is taken and every result seen, then let a commit finish.
  task automatic drain();
    while (req_queue.size() > 0 || in_valid || cmp_queue.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed traffic: calibration, samples, commits and frame walks.
  task automatic add_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 12) add_req(REQ_CAL, 3'($urandom), 3'($urandom_range(4)), pick_value());
      else if (k < 14) add_req(REQ_CAL, 3'($urandom), 3'($urandom_range(7, 5)), 16'($urandom));
      else if (k < 35) add_req(REQ_RAW, 3'($urandom), 3'($urandom), pick_value());
      else if (k < 42) add_req(REQ_COMMIT, 3'($urandom), 3'($urandom), 16'($urandom));
      else add_req(REQ_CMP, 3'($urandom), 3'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_config();
    write_reg(CFG_CHMAP, ($urandom_range(3) == 0) ? 24'hffffff : 24'($urandom));
    write_reg(CFG_MIN_PULSE, 24'($urandom_range(65535)));
    write_reg(CFG_PAUSE, 24'($urandom_range(65535)));
    write_reg(CFG_SYNC, 24'($urandom_range(65535)));
    write_reg(CFG_SCALE, 24'($urandom_range(16383, 1)));
    write_reg(CFG_PERIOD, 24'($urandom_range(65535)));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_CAL;
    in_channel = '0;
    in_cal_field = FLD_LOW;
    in_value = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_CHMAP;
    cfg_wdata = '0;
    m_chmap = CHMAP_RST;
    m_min_pulse = MIN_PULSE_RST;
    m_pause = PAUSE_RST;
    m_sync = SYNC_RST;
    m_scale = SCALE_RST;
    m_period = PERIOD_RST;
    foreach (m_cal[i]) m_cal[i] = '0;
    foreach (m_raw[i]) m_raw[i] = '0;
    foreach (m_slot[b, i]) m_slot[b][i] = MIN_PULSE_RST;
    m_act = 1'b0;
    m_pos = '0;
    m_acc = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: a frame on reset defaults, then calibrate every word before any commit.
    for (int i = 0; i < 18; i++) add_req(REQ_CMP, 3'd0, FLD_LOW, 16'h0);
    for (int c = 0; c < 8; c++) begin
      add_req(REQ_CAL, 3'(c), FLD_LOW, (c == 1) ? 16'h0 : (c == 3) ? 16'h8000 : 16'hfe0c);
      add_req(REQ_CAL, 3'(c), FLD_CEN, (c == 3) ? 16'h7fff : 16'h0005);
      add_req(REQ_CAL, 3'(c), FLD_HIGH, (c == 0) ? 16'h0 : (c == 4) ? 16'hff00 : 16'h01f4);
      add_req(REQ_CAL, 3'(c), FLD_DZ, (c == 2) ? 16'hfff6 : 16'h000a);
      add_req(REQ_CAL, 3'(c), FLD_TRIM, (c == 3) ? 16'h7fff : 16'h0000);
      add_req(REQ_RAW, 3'(c), FLD_LOW, (c[0]) ? 16'h8000 : 16'h7fff);
    end
    add_req(REQ_CAL, 3'd7, 3'd5, 16'hffff);
    add_req(REQ_CAL, 3'd7, 3'd7, 16'hffff);
    add_req(REQ_RAW, 3'd5, FLD_LOW, 16'h0003);
    add_req(REQ_COMMIT, 3'd0, FLD_LOW, 16'h0);
    for (int i = 0; i < 18; i++) add_req(REQ_CMP, 3'd0, FLD_LOW, 16'h0);
    drain();

    // Phase 1: no idling.
    add_random(430);
    drain();
    write_reg(CFG_SCALE, 24'd1);
    write_reg(CFG_MIN_PULSE, 24'd0);
    write_reg(CFG_PAUSE, 24'd65535);
    write_reg(CFG_CHMAP, 24'd0);
    write_reg(CFG_SYNC, 24'd0);
    write_reg(CFG_PERIOD, 24'd65535);

    // Phase 2: sparse sender.
    send_idle_pct = 82;
    add_random(430);
    drain();
    write_reg(CFG_SCALE, 24'd16383);
    write_reg(CFG_MIN_PULSE, 24'd65535);
    write_reg(CFG_PAUSE, 24'd0);
    write_reg(CFG_CHMAP, 24'hffffff);
    write_reg(CFG_SYNC, 24'd65535);
    write_reg(CFG_PERIOD, 24'd0);

    // Phase 3: stalling receiver, with one long hold-off to back up the input.
    send_idle_pct = 0;
    recv_stall_pct = 82;
    long_hold_req <= 1'b1;
    add_random(430);
    drain();
    random_config();

    // Phase 4: both sides idle now and then.
    send_idle_pct = 27;
    recv_stall_pct = 27;
    add_random(430);
    drain();

    if (errors == 0) begin
      $display("rc_ppm_frame_encoder_core_test passed");
    end else begin
      $display("rc_ppm_frame_encoder_core_test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/rpfe_pkg.sv
design/rpfe_ctrl.sv
design/rpfe_dp.sv
design/rc_ppm_frame_encoder_core.sv
design/rpfe_checker.sv
tb/sv/rc_ppm_frame_encoder_core_test.sv
